// ----- src/cacc_pkg.sv -----
// Shared types and constants for the atom clash score accumulator.
// Used by every module of the block; no dependencies of its own.
package cacc_pkg;

  localparam int unsigned COORD_WIDTH = 20;
  localparam int unsigned CUTOFF_WIDTH = 25;
  localparam int unsigned WEIGHT_WIDTH = 16;
  localparam int unsigned ACC_WIDTH = 48;
  localparam int unsigned SCORE_WIDTH = 63;
  localparam int unsigned COUNT_OUT_WIDTH = 11;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  // Axis differences of magnitude 2**MAG_WIDTH (8192) or more never clash.
  localparam int unsigned MAG_WIDTH = 13;
  localparam int unsigned SQ_WIDTH = 2 * MAG_WIDTH;
  localparam int unsigned D2_WIDTH = SQ_WIDTH + 2;

  // Weight times accumulator is formed from 16-bit chunks.
  localparam int unsigned CHUNK_WIDTH = 16;
  localparam int unsigned PROD_WIDTH = WEIGHT_WIDTH + CHUNK_WIDTH;
  localparam int unsigned WSUM_WIDTH = 66;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};
  localparam logic [WSUM_WIDTH-1:0] SCORE_MAX = {3'b000, {SCORE_WIDTH{1'b1}}};

  localparam logic [CUTOFF_WIDTH-1:0] CUTOFF_RESET = 25'd589824;
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 16'd256;

  // Mode codes of an input transaction.
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_PROBE = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CUTOFF_SQ = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WEIGHT_CC = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WEIGHT_CS = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WEIGHT_SS = 2'd3;

  typedef enum logic [1:0] {
    CLS_CORE_CORE,
    CLS_CORE_SURFACE,
    CLS_SURFACE_SURFACE
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DRAIN,
    ST_SCORE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                    mode;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic                          occupied;
    logic                          is_core;
  } in_t;

  typedef struct packed {
    logic [ACC_WIDTH-1:0]       sum_core_core;
    logic [ACC_WIDTH-1:0]       sum_core_surface;
    logic [ACC_WIDTH-1:0]       sum_surface_surface;
    logic [SCORE_WIDTH-1:0]     weighted_score;
    logic [COUNT_OUT_WIDTH-1:0] stored_count;
    logic                       store_overflow;
  } out_t;

  // One stored reference atom; also the held probe atom.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          occupied;
    logic                          is_core;
  } atom_t;

  typedef struct packed {
    logic [WEIGHT_WIDTH-1:0] core_core;
    logic [WEIGHT_WIDTH-1:0] core_surface;
    logic [WEIGHT_WIDTH-1:0] surface_surface;
  } weights_t;

  typedef struct packed {
    logic [ACC_WIDTH-1:0] core_core;
    logic [ACC_WIDTH-1:0] core_surface;
    logic [ACC_WIDTH-1:0] surface_surface;
  } sums_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ----- src/cacc_mem.sv -----
// Reference atom store: one write port, one registered read port.
// Depends on cacc_pkg for the atom entry type.
module cacc_mem import cacc_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  atom_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output atom_t         rdata_o
);

  atom_t mem_q [DEPTH];
  atom_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/cacc_pair.sv -----
// Pair pipeline: distance, cutoff compare and the three saturating clash sums.
// Depends on cacc_pkg; fed by the registered read port of cacc_mem.
module cacc_pair import cacc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  atom_t                   ref_i,
  input  atom_t                   probe_i,
  input  logic [CUTOFF_WIDTH-1:0] cutoff_i,
  input  logic                    clear_i,
  output sums_t                   sums_o,
  output unit_status_t            status_o
);

  // Stage 1: read data valid.
  logic v1_q;
  // Stage 2: axis magnitudes.
  logic                 v2_q;
  logic [MAG_WIDTH-1:0] mx_q, my_q, mz_q;
  cls_e                 cls2_q;
  // Stage 3: squares.
  logic                v3_q;
  logic [SQ_WIDTH-1:0] sx_q, sy_q, sz_q;
  cls_e                cls3_q;
  // Stage 4: clash amount.
  logic                    v4_q;
  logic [CUTOFF_WIDTH-1:0] amt_q;
  cls_e                    cls4_q;

  sums_t acc_q, acc_d;

  logic signed [COORD_WIDTH:0] dx, dy, dz;
  logic [COORD_WIDTH:0]        ax, ay, az;
  logic                        near;
  cls_e                        cls_d;
  logic [D2_WIDTH-1:0]         d2;
  logic [D2_WIDTH-1:0]         cut_ext;
  logic                        hit;

  function automatic logic [COORD_WIDTH:0] mag(input logic signed [COORD_WIDTH:0] v);
    logic [COORD_WIDTH:0] r;
    r = v[COORD_WIDTH] ? $unsigned(-v) : $unsigned(v);
    return r;
  endfunction

  function automatic logic [ACC_WIDTH-1:0] add_sat(input logic [ACC_WIDTH-1:0] a,
                                                    input logic [CUTOFF_WIDTH-1:0] b);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, a} + {{(ACC_WIDTH + 1 - CUTOFF_WIDTH){1'b0}}, b};
    return s[ACC_WIDTH] ? ACC_MAX : s[ACC_WIDTH-1:0];
  endfunction

  always_comb begin
    dx = {probe_i.x[COORD_WIDTH-1], probe_i.x} - {ref_i.x[COORD_WIDTH-1], ref_i.x};
    dy = {probe_i.y[COORD_WIDTH-1], probe_i.y} - {ref_i.y[COORD_WIDTH-1], ref_i.y};
    dz = {probe_i.z[COORD_WIDTH-1], probe_i.z} - {ref_i.z[COORD_WIDTH-1], ref_i.z};
    ax = mag(dx);
    ay = mag(dy);
    az = mag(dz);
    near = (ax[COORD_WIDTH:MAG_WIDTH] == '0) && (ay[COORD_WIDTH:MAG_WIDTH] == '0) &&
           (az[COORD_WIDTH:MAG_WIDTH] == '0);
    if (probe_i.is_core && ref_i.is_core) begin
      cls_d = CLS_CORE_CORE;
    end else if (!probe_i.is_core && !ref_i.is_core) begin
      cls_d = CLS_SURFACE_SURFACE;
    end else begin
      cls_d = CLS_CORE_SURFACE;
    end
  end

  always_comb begin
    d2 = D2_WIDTH'(sx_q) + D2_WIDTH'(sy_q) + D2_WIDTH'(sz_q);
    cut_ext = D2_WIDTH'(cutoff_i);
    hit = d2 < cut_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= rd_en_i;
      v2_q <= v1_q && ref_i.occupied && near;
      v3_q <= v2_q;
      v4_q <= v3_q && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= ax[MAG_WIDTH-1:0];
    my_q   <= ay[MAG_WIDTH-1:0];
    mz_q   <= az[MAG_WIDTH-1:0];
    cls2_q <= cls_d;
    sx_q   <= mx_q * mx_q;
    sy_q   <= my_q * my_q;
    sz_q   <= mz_q * mz_q;
    cls3_q <= cls2_q;
    amt_q  <= cutoff_i - d2[CUTOFF_WIDTH-1:0];
    cls4_q <= cls3_q;
  end

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (v4_q) begin
      unique case (cls4_q)
        CLS_CORE_CORE:       acc_d.core_core = add_sat(acc_q.core_core, amt_q);
        CLS_SURFACE_SURFACE: acc_d.surface_surface = add_sat(acc_q.surface_surface, amt_q);
        default:             acc_d.core_surface = add_sat(acc_q.core_surface, amt_q);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign sums_o = acc_q;
  assign status_o.busy = v1_q || v2_q || v3_q || v4_q;
  assign status_o.done = 1'b0;

endmodule

// ----- src/cacc_mac.sv -----
// Shared 16x16 multiply-accumulate that forms the weighted clash score.
// Depends on cacc_pkg; steps through three classes times three chunks.
module cacc_mac import cacc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  weights_t               weights_i,
  input  sums_t                  sums_i,
  output logic [SCORE_WIDTH-1:0] score_o,
  output unit_status_t           status_o
);

  logic                  run_q;
  cls_e                  cls_q;
  logic [1:0]            chunk_q;
  logic                  pv_q;
  logic [1:0]            sh_q;
  logic [PROD_WIDTH-1:0] prod_q;
  logic [WSUM_WIDTH-1:0] sum_q;
  logic                  done_q;

  logic [WEIGHT_WIDTH-1:0] w_sel;
  logic [ACC_WIDTH-1:0]    a_sel;
  logic [CHUNK_WIDTH-1:0]  c_sel;
  logic                    last;
  logic [WSUM_WIDTH-1:0]   shifted;

  always_comb begin
    unique case (cls_q)
      CLS_CORE_CORE:       begin w_sel = weights_i.core_core;       a_sel = sums_i.core_core; end
      CLS_CORE_SURFACE:    begin w_sel = weights_i.core_surface;    a_sel = sums_i.core_surface; end
      CLS_SURFACE_SURFACE: begin
        w_sel = weights_i.surface_surface;
        a_sel = sums_i.surface_surface;
      end
      default:             begin w_sel = '0;                        a_sel = '0; end
    endcase
    unique case (chunk_q)
      2'd0:    c_sel = a_sel[CHUNK_WIDTH-1:0];
      2'd1:    c_sel = a_sel[2*CHUNK_WIDTH-1:CHUNK_WIDTH];
      default: c_sel = a_sel[3*CHUNK_WIDTH-1:2*CHUNK_WIDTH];
    endcase
    last = (cls_q == CLS_SURFACE_SURFACE) && (chunk_q == 2'd2);
    unique case (sh_q)
      2'd0:    shifted = WSUM_WIDTH'(prod_q);
      2'd1:    shifted = WSUM_WIDTH'(prod_q) << CHUNK_WIDTH;
      default: shifted = WSUM_WIDTH'(prod_q) << (2 * CHUNK_WIDTH);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cls_q   <= CLS_CORE_CORE;
      chunk_q <= 2'd0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pv_q   <= run_q;
      done_q <= pv_q && !run_q;
      if (start_i) begin
        run_q   <= 1'b1;
        cls_q   <= CLS_CORE_CORE;
        chunk_q <= 2'd0;
      end else if (run_q) begin
        // Advance chunk first, then class.
        if (last) begin
          run_q <= 1'b0;
        end else if (chunk_q == 2'd2) begin
          chunk_q <= 2'd0;
          cls_q   <= (cls_q == CLS_CORE_CORE) ? CLS_CORE_SURFACE : CLS_SURFACE_SURFACE;
        end else begin
          chunk_q <= chunk_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= w_sel * c_sel;
    sh_q   <= chunk_q;
    if (start_i) begin
      sum_q <= '0;
    end else if (pv_q) begin
      sum_q <= sum_q + shifted;
    end
  end

  assign score_o = (sum_q >= SCORE_MAX) ? SCORE_MAX[SCORE_WIDTH-1:0] : sum_q[SCORE_WIDTH-1:0];
  assign status_o.busy = run_q || pv_q;
  assign status_o.done = done_q;

endmodule

// ----- src/atom_clash_score_accumulator_core.sv -----
// Load, unused mode and an unoccupied probe leave the block idle; a probe against N
// stored atoms reads one pair per cycle through the store's single read port into the
// pair pipeline (read, magnitudes, squares, clash amount, accumulate), which drains
// before idle; a report takes nine passes through the shared 16x16 multiplier, then
// is loaded into the output register once that is free. Throughput: one transaction
// in flight at a time. Reset clears count, sums and flags and restores the reset
// configuration; the atom store is not cleared and needs no sweep.
module atom_clash_score_accumulator_core import cacc_pkg::*; #(
  parameter int unsigned MAX_REF_ATOMS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_t                     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_t                    out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CUTOFF_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_REF_ATOMS > 1) ? $clog2(MAX_REF_ATOMS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_REF_ATOMS + 1);
  localparam logic [CNTW-1:0] COUNT_MAX = CNTW'(MAX_REF_ATOMS);

  // Configuration registers.
  logic [CUTOFF_WIDTH-1:0] cutoff_q;
  weights_t                weights_q;

  // Control state.
  state_e          state_q, state_d;
  logic [CNTW-1:0] count_q;
  logic            overflow_q;
  logic [CNTW-1:0] rd_idx_q;
  atom_t           probe_q;
  logic            out_valid_q;
  out_t            out_q;

  // Decoded handshake and sequencer controls.
  logic in_fire;
  logic out_fire;
  logic do_load, do_probe, do_report;
  logic last_rd;
  logic rd_en;
  logic mac_start;
  logic out_load;

  atom_t          wr_atom;
  atom_t          rd_atom;
  sums_t          sums;
  unit_status_t   pair_st;
  unit_status_t   mac_st;
  logic [SCORE_WIDTH-1:0] score;
  logic [CNTW+COUNT_OUT_WIDTH-1:0] count_ext;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_fire  = out_valid_q && !out_stall_i;
  assign do_load   = in_fire && (in_data_i.mode == MODE_LOAD);
  assign do_probe  = in_fire && (in_data_i.mode == MODE_PROBE) && in_data_i.occupied &&
                     (count_q != '0);
  assign do_report = in_fire && (in_data_i.mode == MODE_REPORT);
  assign last_rd   = (rd_idx_q == count_q - CNTW'(1));

  assign wr_atom.x        = in_data_i.coord_x;
  assign wr_atom.y        = in_data_i.coord_y;
  assign wr_atom.z        = in_data_i.coord_z;
  assign wr_atom.occupied = in_data_i.occupied;
  assign wr_atom.is_core  = in_data_i.is_core;

  // Configuration writes; the user must keep the block idle when these arrive (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q                  <= CUTOFF_RESET;
      weights_q.core_core       <= WEIGHT_RESET;
      weights_q.core_surface    <= WEIGHT_RESET;
      weights_q.surface_surface <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CUTOFF_SQ: cutoff_q                  <= cfg_data_i;
        CFG_WEIGHT_CC: weights_q.core_core       <= cfg_data_i[WEIGHT_WIDTH-1:0];
        CFG_WEIGHT_CS: weights_q.core_surface    <= cfg_data_i[WEIGHT_WIDTH-1:0];
        default:       weights_q.surface_surface <= cfg_data_i[WEIGHT_WIDTH-1:0];
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_probe) begin
          state_d = ST_PROBE;
        end else if (do_report) begin
          state_d = ST_SCORE;
        end
      end
      ST_PROBE: begin
        if (last_rd) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pair_st.busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCORE: begin
        if (mac_st.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    mac_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        mac_start  = do_report;
      end
      ST_PROBE: rd_en = 1'b1;
      ST_OUT:   out_load = !out_valid_q || !out_stall_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      overflow_q <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      state_q <= state_d;
      // Store a reference atom, or drop it and flag a full store; loading a report clears both.
      if (do_load) begin
        if (count_q < COUNT_MAX) begin
          count_q <= count_q + CNTW'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end else if (out_load) begin
        count_q    <= '0;
        overflow_q <= 1'b0;
      end
      // Walk the store once per probe.
      if (do_probe) begin
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + CNTW'(1);
      end
    end
  end

  // Hold the probe atom for the whole walk.
  always_ff @(posedge clk_i) begin
    if (do_probe) begin
      probe_q <= wr_atom;
    end
  end

  cacc_mem #(
    .DEPTH (MAX_REF_ATOMS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (do_load && (count_q < COUNT_MAX)),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_atom),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rd_atom)
  );

  cacc_pair u_pair (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .ref_i    (rd_atom),
    .probe_i  (probe_q),
    .cutoff_i (cutoff_q),
    .clear_i  (out_load),
    .sums_o   (sums),
    .status_o (pair_st)
  );

  cacc_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mac_start),
    .weights_i (weights_q),
    .sums_i    (sums),
    .score_o   (score),
    .status_o  (mac_st)
  );

  // Output register: load the report, drop it once taken.
  assign count_ext = {{COUNT_OUT_WIDTH{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.sum_core_core       <= sums.core_core;
      out_q.sum_core_surface    <= sums.core_surface;
      out_q.sum_surface_surface <= sums.surface_surface;
      out_q.weighted_score      <= score;
      out_q.stored_count        <= count_ext[COUNT_OUT_WIDTH-1:0];
      out_q.store_overflow      <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- bench/tb_atom_clash_score_accumulator_core.sv -----
// Self-checking testbench for atom_clash_score_accumulator_core.
// Depends on cacc_pkg for the transaction structs, mode codes and register indexes;
// holds its own clash predictor and report queue in a small scoreboard class.
module tb_atom_clash_score_accumulator_core;
  import cacc_pkg::*;

  localparam int unsigned MAX_ATOMS = 1024;
  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned IDLE_PERCENT = 8;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned ROUNDS_PER_SETTING = 8;
  // Long enough for a full-store probe or a report to finish; leave margin.
  localparam int unsigned DRAIN_CYCLES = MAX_ATOMS + 32;
  localparam int unsigned PRESSURE_AFTER = 5;
  localparam int unsigned PRESSURE_CYCLES = 600;
  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned CUTOFF_TOP = 1 << 24;
  localparam int unsigned WEIGHT_TOP = (1 << WEIGHT_WIDTH) - 1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam longint AXIS_LIMIT = longint'(1) << MAG_WIDTH;
  localparam logic [63:0] ACC_CAP = {16'b0, ACC_MAX};
  localparam logic [63:0] SCORE_CAP = {1'b0, {SCORE_WIDTH{1'b1}}};

  // Scoreboard: mirrors the atom store, the three clash sums and the registers,
  // and queues one expected report per accepted report transaction.
  class clash_ledger;
    logic [CUTOFF_WIDTH-1:0] cutoff = CUTOFF_RESET;
    logic [WEIGHT_WIDTH-1:0] w_cc = WEIGHT_RESET;
    logic [WEIGHT_WIDTH-1:0] w_cs = WEIGHT_RESET;
    logic [WEIGHT_WIDTH-1:0] w_ss = WEIGHT_RESET;
    logic signed [COORD_WIDTH-1:0] atom_x [MAX_ATOMS];
    logic signed [COORD_WIDTH-1:0] atom_y [MAX_ATOMS];
    logic signed [COORD_WIDTH-1:0] atom_z [MAX_ATOMS];
    bit atom_occ [MAX_ATOMS];
    bit atom_core [MAX_ATOMS];
    int unsigned atom_count;
    logic [63:0] acc_cc = '0;
    logic [63:0] acc_cs = '0;
    logic [63:0] acc_ss = '0;
    bit overflow_seen;
    out_t pending_reports[$];
    int unsigned failures, reports_noted, reports_checked;
    int unsigned loads_noted, drops_noted, probes_noted, pairs_clashed, settings_used;

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CUTOFF_WIDTH-1:0] value);
      case (idx)
        CFG_CUTOFF_SQ: cutoff = value;
        CFG_WEIGHT_CC: w_cc = value[WEIGHT_WIDTH-1:0];
        CFG_WEIGHT_CS: w_cs = value[WEIGHT_WIDTH-1:0];
        CFG_WEIGHT_SS: w_ss = value[WEIGHT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
      if (a >= cap || b >= cap || b > cap - a) return cap;
      return a + b;
    endfunction

    function logic [63:0] weigh(logic [WEIGHT_WIDTH-1:0] w, logic [63:0] acc);
      logic [63:0] p;
      p = 64'(w);
      return p * acc;
    endfunction

    function void probe_store(in_t t);
      longint dx, dy, dz, d2, lim;
      lim = longint'(cutoff);
      for (int i = 0; i < atom_count; i++) begin
        if (!atom_occ[i]) continue;
        dx = longint'($signed(t.coord_x)) - longint'(atom_x[i]);
        dy = longint'($signed(t.coord_y)) - longint'(atom_y[i]);
        dz = longint'($signed(t.coord_z)) - longint'(atom_z[i]);
        if (dx <= -AXIS_LIMIT || dx >= AXIS_LIMIT || dy <= -AXIS_LIMIT ||
            dy >= AXIS_LIMIT || dz <= -AXIS_LIMIT || dz >= AXIS_LIMIT) continue;
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 >= lim) continue;
        pairs_clashed++;
        if (t.is_core && atom_core[i]) acc_cc = sat_add(acc_cc, lim - d2, ACC_CAP);
        else if (!t.is_core && !atom_core[i]) acc_ss = sat_add(acc_ss, lim - d2, ACC_CAP);
        else acc_cs = sat_add(acc_cs, lim - d2, ACC_CAP);
      end
    endfunction

    function void close_report();
      out_t want;
      logic [63:0] score;
      score = '0;
      score = sat_add(score, weigh(w_cc, acc_cc), SCORE_CAP);
      score = sat_add(score, weigh(w_cs, acc_cs), SCORE_CAP);
      score = sat_add(score, weigh(w_ss, acc_ss), SCORE_CAP);
      want.sum_core_core = acc_cc[ACC_WIDTH-1:0];
      want.sum_core_surface = acc_cs[ACC_WIDTH-1:0];
      want.sum_surface_surface = acc_ss[ACC_WIDTH-1:0];
      want.weighted_score = score[SCORE_WIDTH-1:0];
      want.stored_count = atom_count[COUNT_OUT_WIDTH-1:0];
      want.store_overflow = overflow_seen;
      pending_reports.push_back(want);
      reports_noted++;
      // Report clears the store, the sums and the overflow flag.
      atom_count = 0;
      acc_cc = '0;
      acc_cs = '0;
      acc_ss = '0;
      overflow_seen = 1'b0;
    endfunction

    function void note_transaction(in_t t);
      case (t.mode)
        MODE_LOAD: begin
          loads_noted++;
          if (atom_count < MAX_ATOMS) begin
            atom_x[atom_count] = t.coord_x;
            atom_y[atom_count] = t.coord_y;
            atom_z[atom_count] = t.coord_z;
            atom_occ[atom_count] = t.occupied;
            atom_core[atom_count] = t.is_core;
            atom_count++;
          end else begin
            overflow_seen = 1'b1;
            drops_noted++;
          end
        end
        MODE_PROBE: begin
          probes_noted++;
          if (t.occupied) probe_store(t);
        end
        MODE_REPORT: close_report();
        default: ;
      endcase
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (pending_reports.size() == 0) begin
        $error("report transaction with none pending: %p", got);
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      field_check("sum_core_core", want.sum_core_core, got.sum_core_core);
      field_check("sum_core_surface", want.sum_core_surface, got.sum_core_surface);
      field_check("sum_surface_surface", want.sum_surface_surface, got.sum_surface_surface);
      field_check("weighted_score", want.weighted_score, got.weighted_score);
      field_check("stored_count", want.stored_count, got.stored_count);
      field_check("store_overflow", want.store_overflow, got.store_overflow);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [CUTOFF_WIDTH-1:0] cfg_data_i;

  clash_ledger ledger;
  bit calm;                  // suppress idling on both sides
  int unsigned items_sent;   // accepted transactions of any mode but the unused one
  int unsigned quiet_cycles;

  atom_clash_score_accumulator_core #(
    .MAX_REF_ATOMS(MAX_ATOMS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Observe both channels at every edge: check the report first, then note the
  // input, and count cycles without any transaction for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) ledger.check_report(out_data_o);
      if (in_valid_i && !in_stall_o) ledger.note_transaction(in_data_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, except during the calm window. Once, after a few
  // reports, hold off for a long stretch so the block backs up into its input.
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && ledger.reports_checked >= PRESSURE_AFTER) begin
        out_stall_i <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  function automatic in_t make_atom(logic [1:0] mode, int x, int y, int z, bit occ, bit core);
    in_t t;
    t.mode = mode;
    t.coord_x = x[COORD_WIDTH-1:0];
    t.coord_y = y[COORD_WIDTH-1:0];
    t.coord_z = z[COORD_WIDTH-1:0];
    t.occupied = occ;
    t.is_core = core;
    return t;
  endfunction

  function automatic int near(int center, int spread);
    return center + int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic bit mostly_occupied();
    return $urandom_range(99) < 85;
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(1));
  endfunction

  // Any mode, coordinates over the whole range.
  function automatic in_t noise_item();
    logic [1:0] mode;
    mode = 2'($urandom_range(3));
    return make_atom(mode, int'($urandom), int'($urandom), int'($urandom), coin(), coin());
  endfunction

  // Offer one transaction and hold it until accepted; keep valid high afterwards
  // so back-to-back transactions see no bubble unless an idle gap is drawn.
  task automatic send_item(input in_t item);
    if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (item.mode != MODE_UNUSED) items_sent++;
  endtask

  // Drop valid, wait for every pending report, then let a full-store probe drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(int unsigned cutoff, int unsigned wcc, int unsigned wcs,
                              int unsigned wss);
    logic [CFG_IDX_WIDTH-1:0] idx [4];
    logic [CUTOFF_WIDTH-1:0] vals [4];
    idx = '{CFG_CUTOFF_SQ, CFG_WEIGHT_CC, CFG_WEIGHT_CS, CFG_WEIGHT_SS};
    vals = '{CUTOFF_WIDTH'(cutoff), CUTOFF_WIDTH'(wcc), CUTOFF_WIDTH'(wcs),
             CUTOFF_WIDTH'(wss)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      ledger.write_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    ledger.settings_used++;
  endtask

  task automatic apply_setting(int unsigned k);
    case (k)
      0: program_regs(CUTOFF_RESET, WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET);
      1: program_regs(CUTOFF_TOP, WEIGHT_TOP, WEIGHT_TOP, WEIGHT_TOP);
      2: program_regs(0, 0, 0, 0);
      3: program_regs(1, 1, 0, WEIGHT_TOP);
      4: program_regs(CUTOFF_RESET, WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET);
      5: program_regs(CUTOFF_TOP, 0, WEIGHT_TOP, 1);
      default: program_regs($urandom_range(CUTOFF_TOP), $urandom_range(WEIGHT_TOP),
                            $urandom_range(WEIGHT_TOP), $urandom_range(WEIGHT_TOP));
    endcase
  endtask

  // Hand-picked cases under the reset registers (cutoff 3.0 A = 768 counts).
  task automatic run_directed();
    send_item(make_atom(MODE_LOAD, 0, 0, 0, 1, 1));
    send_item(make_atom(MODE_LOAD, 768, 0, 0, 1, 0));
    send_item(make_atom(MODE_LOAD, -524288, -524288, -524288, 1, 1));
    send_item(make_atom(MODE_LOAD, 524287, 524287, 524287, 1, 0));
    send_item(make_atom(MODE_LOAD, 100, 100, 100, 0, 1));
    // Just inside the cutoff against the core atom, one count off the surface one.
    send_item(make_atom(MODE_PROBE, 767, 0, 0, 1, 1));
    // Coincident with the core atom; exactly on the cutoff for the surface atom.
    send_item(make_atom(MODE_PROBE, 0, 0, 0, 1, 0));
    // One axis at the difference limit: never a clash.
    send_item(make_atom(MODE_PROBE, 8192, 0, 0, 1, 1));
    send_item(make_atom(MODE_PROBE, -524288, -524288, -524288, 1, 1));
    send_item(make_atom(MODE_PROBE, 524287, 524287, 524287, 1, 0));
    // Near the unoccupied atom: it must be skipped, the others still count.
    send_item(make_atom(MODE_PROBE, 100, 100, 100, 1, 1));
    send_item(make_atom(MODE_PROBE, 0, 0, 0, 0, 1));
    send_item(make_atom(MODE_UNUSED, 1234, -5678, 91011, 1, 1));
    send_item(make_atom(MODE_REPORT, 0, 0, 0, 0, 0));
    // Report right after a report, then a probe on an empty store.
    send_item(make_atom(MODE_REPORT, -1, -1, -1, 1, 1));
    send_item(make_atom(MODE_PROBE, 0, 0, 0, 1, 1));
    send_item(make_atom(MODE_REPORT, 0, 0, 0, 1, 0));
  endtask

  // One load-probe-report sequence around a random center, with some noise
  // mixed in and the occasional missing or doubled report.
  task automatic run_round();
    int cx, cy, cz, spread, n_loads, n_probes, pick;
    cx = near(0, 400000);
    cy = near(0, 400000);
    cz = near(0, 400000);
    case ($urandom_range(3))
      0: spread = 64;
      1: spread = 768;
      2: spread = 2048;
      default: spread = 8192;
    endcase
    pick = $urandom_range(99);
    if (pick < 80) n_loads = $urandom_range(12, 1);
    else if (pick < 95) n_loads = $urandom_range(64, 13);
    else n_loads = $urandom_range(200, 65);
    n_probes = $urandom_range(6, 1);
    repeat (n_loads) begin
      if ($urandom_range(99) < 10) send_item(noise_item());
      else send_item(make_atom(MODE_LOAD, near(cx, spread), near(cy, spread),
                               near(cz, spread), mostly_occupied(), coin()));
    end
    repeat (n_probes) begin
      if ($urandom_range(99) < 10) send_item(noise_item());
      else send_item(make_atom(MODE_PROBE, near(cx, spread), near(cy, spread),
                               near(cz, spread), mostly_occupied(), coin()));
    end
    pick = $urandom_range(99);
    if (pick < 90) send_item(make_atom(MODE_REPORT, cx, cy, cz, 1, 1));
    if (pick >= 95) repeat (2) send_item(make_atom(MODE_REPORT, 0, 0, 0, 0, 0));
  endtask

  initial begin : stimulus
    int unsigned start_items, rounds, setting;
    ledger = new;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CUTOFF_SQ;
    cfg_data_i = '0;
    calm = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    settle();
    apply_setting(1);

    // Random rounds; rotate the registers every few rounds while idle.
    start_items = items_sent;
    rounds = 0;
    setting = 2;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (rounds % ROUNDS_PER_SETTING == 0) begin
        settle();
        apply_setting(setting);
        setting++;
      end
      calm = (rounds >= 6 && rounds < 14);
      run_round();
      rounds++;
    end
    calm = 1'b0;
    settle();

    $display("Covered %0d loads (%0d dropped), %0d probes, %0d clashing pairs.",
             ledger.loads_noted, ledger.drops_noted, ledger.probes_noted, ledger.pairs_clashed);
    $display("Checked %0d reports across %0d register settings.",
             ledger.reports_checked, ledger.settings_used + 1);
    if (ledger.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cacc_pkg.sv
src/cacc_mem.sv
src/cacc_pair.sv
src/cacc_mac.sv
src/atom_clash_score_accumulator_core.sv
bench/tb_atom_clash_score_accumulator_core.sv
